// ===== src/irss_pkg.sv =====
// Shared types and constants for the record stream statistics block.
// No dependencies; used by every other file of the block except the two interfaces.
package irss_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [2:0] OP_BYTE      = 3'd0;
	localparam logic [2:0] OP_END       = 3'd1;
	localparam logic [2:0] OP_CLR_PEAK  = 3'd2;
	localparam logic [2:0] OP_RESTART   = 3'd3;
	localparam logic [2:0] OP_FAIL      = 3'd4;

	localparam logic [2:0]  DEFAULT_SAMPLE_BYTES = 3'd2;
	localparam logic [15:0] LOST_MARKER          = 16'hFFFF;
	localparam logic [15:0] MIN_LEN_RESET        = 16'hFFFF;

	// command handed from the parser to the statistics side
	typedef struct packed {
		logic        commit;
		logic        lost;
		logic        error;
		logic        xfer;
		logic        clr_peak;
		logic        restart;
		logic [15:0] len;
		logic [15:0] peak;
	} cmd_t;

endpackage

// ===== src/irss_in_if.sv =====
// Input request channel: valid/ready handshake with op code and buffer byte.
// No dependencies.
interface irss_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

// ===== src/irss_out_if.sv =====
// Result request channel: valid/ready handshake with the statistics snapshot.
// No dependencies.
interface irss_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] packet_count;
	logic [31:0] byte_count;
	logic [31:0] lost_count;
	logic [31:0] error_count;
	logic [31:0] transfer_count;
	logic [15:0] shortest_record;
	logic [15:0] longest_record;
	logic [15:0] peak_level;

	modport source (output valid, output packet_count, output byte_count,
		output lost_count, output error_count, output transfer_count,
		output shortest_record, output longest_record, output peak_level,
		input ready);
	modport sink (input valid, input packet_count, input byte_count,
		input lost_count, input error_count, input transfer_count,
		input shortest_record, input longest_record, input peak_level,
		output ready);
endinterface

// ===== src/irss_queue.sv =====
// Small register queue between parser and statistics side.
// Depends on irss_pkg (cmd_t).
module irss_queue #(
	parameter int unsigned DEPTH = irss_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  irss_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output irss_pkg::cmd_t  pop_data
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	irss_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== src/irss_front.sv =====
// Front end: accepts requests, parses the length-prefixed record stream and
// tracks the in-record peak. Depends on irss_pkg and irss_in_if.
module irss_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_wdata,
	irss_in_if.sink        item,
	output logic           push,
	output irss_pkg::cmd_t push_data,
	input  logic           full
);
	typedef enum logic [1:0] {
		PH_LEN_LOW,
		PH_LEN_HIGH,
		PH_PAYLOAD
	} phase_t;

	phase_t      phase_q,   phase_d;
	logic [7:0]  low_q,     low_d;
	logic [15:0] rec_len_q, rec_len_d;
	logic [15:0] left_q,    left_d;
	logic [2:0]  pos_q,     pos_d;
	logic [7:0]  held_q,    held_d;
	logic [15:0] peak_q,    peak_d;
	logic [2:0]  sbytes_q;

	logic        accept;
	logic [2:0]  n_eff;
	logic [15:0] mag_one;
	logic [15:0] word;
	logic [15:0] mag_two;
	logic [15:0] len;
	logic [15:0] left_dec;
	logic [2:0]  pos_inc;
	logic        have;
	logic [15:0] mag;
	logic [15:0] peak_new;

	assign item.ready = !full;
	assign accept     = item.valid && !full;

	assign n_eff    = (sbytes_q == '0) ? irss_pkg::DEFAULT_SAMPLE_BYTES : sbytes_q;
	assign mag_one  = item.data_byte[7] ? {8'(~item.data_byte + 8'd1), 8'h00}
		: {item.data_byte, 8'h00};
	assign word     = {item.data_byte, held_q};
	assign mag_two  = word[15] ? 16'(~word + 16'd1) : word;
	assign len      = {item.data_byte, low_q};
	assign left_dec = left_q - 16'd1;
	assign pos_inc  = pos_q + 3'd1;

	always_comb begin
		have = 1'b0;
		mag  = mag_two;
		if (n_eff == 3'd1) begin
			have = 1'b1;
			mag  = mag_one;
		end else if (pos_q == n_eff - 3'd1) begin
			have = 1'b1;
		end
	end

	assign peak_new = (have && (mag > peak_q)) ? mag : peak_q;

	always_comb begin
		phase_d   = phase_q;
		low_d     = low_q;
		rec_len_d = rec_len_q;
		left_d    = left_q;
		pos_d     = pos_q;
		held_d    = held_q;
		peak_d    = peak_q;
		push      = 1'b0;
		push_data = '0;
		if (accept) begin
			unique case (item.op)
				irss_pkg::OP_BYTE: begin
					push = 1'b1;
					unique case (phase_q)
						PH_LEN_LOW: begin
							low_d   = item.data_byte;
							phase_d = PH_LEN_HIGH;
						end
						PH_LEN_HIGH: begin
							rec_len_d = len;
							left_d    = len;
							pos_d     = '0;
							held_d    = '0;
							peak_d    = '0;
							phase_d   = PH_PAYLOAD;
							if (len == irss_pkg::LOST_MARKER) begin
								push_data.lost = 1'b1;
								phase_d        = PH_LEN_LOW;
								low_d          = '0;
								rec_len_d      = '0;
								left_d         = '0;
							end else if (len == '0) begin
								push_data.commit = 1'b1;
								phase_d          = PH_LEN_LOW;
								low_d            = '0;
							end
						end
						PH_PAYLOAD: begin
							if (n_eff != 3'd1 && pos_q == n_eff - 3'd2) begin
								held_d = item.data_byte;
							end
							peak_d = peak_new;
							pos_d  = (pos_inc >= n_eff) ? '0 : pos_inc;
							left_d = left_dec;
							if (left_dec == '0) begin
								push_data.commit = 1'b1;
								push_data.len    = rec_len_q;
								push_data.peak   = peak_new;
								phase_d   = PH_LEN_LOW;
								low_d     = '0;
								rec_len_d = '0;
								pos_d     = '0;
								held_d    = '0;
								peak_d    = '0;
							end
						end
						default: begin
							phase_d = PH_LEN_LOW;
						end
					endcase
				end
				irss_pkg::OP_END, irss_pkg::OP_FAIL: begin
					push = 1'b1;
					if (item.op == irss_pkg::OP_END) begin
						push_data.xfer  = 1'b1;
						push_data.error = (phase_q == PH_PAYLOAD);
					end else begin
						push_data.error = 1'b1;
					end
					phase_d   = PH_LEN_LOW;
					low_d     = '0;
					rec_len_d = '0;
					left_d    = '0;
					pos_d     = '0;
					held_d    = '0;
					peak_d    = '0;
				end
				irss_pkg::OP_CLR_PEAK: begin
					push               = 1'b1;
					push_data.clr_peak = 1'b1;
				end
				irss_pkg::OP_RESTART: begin
					push              = 1'b1;
					push_data.restart = 1'b1;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN_LOW;
			low_q     <= '0;
			rec_len_q <= '0;
			left_q    <= '0;
			pos_q     <= '0;
			held_q    <= '0;
			peak_q    <= '0;
			sbytes_q  <= irss_pkg::DEFAULT_SAMPLE_BYTES;
		end else begin
			phase_q   <= phase_d;
			low_q     <= low_d;
			rec_len_q <= rec_len_d;
			left_q    <= left_d;
			pos_q     <= pos_d;
			held_q    <= held_d;
			peak_q    <= peak_d;
			if (cfg_we) begin
				sbytes_q <= cfg_wdata;
			end
		end
	end
endmodule

// ===== src/irss_back.sv =====
// Back end: applies queued requests to the counters, length limits and peak,
// and holds the result register. Depends on irss_pkg and irss_out_if.
module irss_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  irss_pkg::cmd_t cmd,
	output logic           pop,
	irss_out_if.source     result
);
	logic [31:0] pkt_q,   pkt_d;
	logic [31:0] bytes_q, bytes_d;
	logic [31:0] lost_q,  lost_d;
	logic [31:0] err_q,   err_d;
	logic [31:0] xfer_q,  xfer_d;
	logic [15:0] min_q,   min_d;
	logic [15:0] max_q,   max_d;
	logic [15:0] peak_q,  peak_d;
	logic        valid_q;

	assign pop = not_empty && (!valid_q || result.ready);

	always_comb begin
		pkt_d   = pkt_q;
		bytes_d = bytes_q;
		lost_d  = lost_q;
		err_d   = err_q;
		xfer_d  = xfer_q;
		min_d   = min_q;
		max_d   = max_q;
		peak_d  = peak_q;
		if (cmd.restart) begin
			pkt_d   = '0;
			bytes_d = '0;
			lost_d  = '0;
			err_d   = '0;
			xfer_d  = '0;
			min_d   = irss_pkg::MIN_LEN_RESET;
			max_d   = '0;
			peak_d  = '0;
		end
		if (cmd.clr_peak) begin
			peak_d = '0;
		end
		if (cmd.commit) begin
			pkt_d   = pkt_q + 32'd1;
			bytes_d = bytes_q + 32'(cmd.len);
			if (cmd.len < min_q) begin
				min_d = cmd.len;
			end
			if (cmd.len > max_q) begin
				max_d = cmd.len;
			end
			if (cmd.peak > peak_q) begin
				peak_d = cmd.peak;
			end
		end
		if (cmd.lost) begin
			lost_d = lost_q + 32'd1;
		end
		if (cmd.error) begin
			err_d = err_q + 32'd1;
		end
		if (cmd.xfer) begin
			xfer_d = xfer_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q   <= '0;
			bytes_q <= '0;
			lost_q  <= '0;
			err_q   <= '0;
			xfer_q  <= '0;
			min_q   <= irss_pkg::MIN_LEN_RESET;
			max_q   <= '0;
			peak_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pkt_q   <= pkt_d;
				bytes_q <= bytes_d;
				lost_q  <= lost_d;
				err_q   <= err_d;
				xfer_q  <= xfer_d;
				min_q   <= min_d;
				max_q   <= max_d;
				peak_q  <= peak_d;
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// statistics registers only move on a pop, so they double as the result
	assign result.valid           = valid_q;
	assign result.packet_count    = pkt_q;
	assign result.byte_count      = bytes_q;
	assign result.lost_count      = lost_q;
	assign result.error_count     = err_q;
	assign result.transfer_count  = xfer_q;
	assign result.shortest_record = min_q;
	assign result.longest_record  = max_q;
	assign result.peak_level      = peak_q;
endmodule

// ===== src/iso_record_stream_statistics_core.sv =====
// Top level of the record stream statistics block.
// Depends on irss_pkg, irss_in_if, irss_out_if, irss_queue, irss_front, irss_back.
//
// Usage:
//   item   - input requests: op (byte, transfer end, clear peak, restart
//            statistics, failed transfer) and data_byte. Unused op codes are
//            taken and dropped with no result.
//   result - one statistics snapshot for every op 0..4, in order.
//   cfg_we / cfg_wdata - write of sample_bytes; write only while idle.
// A taken request is written into the queue, then applied to the statistics registers, which raise result valid.
// Throughput: one request per cycle unless the result stalls; the front parser updates its state
//   for every taken request and the statistics side commits one queued request a cycle.
// Stalls: result holds while ready is low; the queue between the parser and
//   the statistics side fills, then item.ready drops.
// Reset: arst_n clears all counters, the peak and parse state, sets the
//   shortest length to 65535 and sample_bytes to 2; no clearing pass.
module iso_record_stream_statistics_core #(
	parameter int unsigned QUEUE_DEPTH = irss_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	irss_in_if.sink    item,
	irss_out_if.source result
);
	logic           push;
	logic           full;
	logic           pop;
	logic           not_empty;
	irss_pkg::cmd_t push_data;
	irss_pkg::cmd_t pop_data;

	irss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	irss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	irss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.cmd       (pop_data),
		.pop       (pop),
		.result    (result)
	);
endmodule

// ===== sim/tb.sv =====
// Testbench for iso_record_stream_statistics_core: random and directed byte streams
// checked against a behavioural predictor of the record parser and statistics.
// Depends on irss_pkg, irss_in_if, irss_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb;
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
	localparam int         ITEMS_PER_PHASE = 30;
	localparam int         LONG_HOLD       = 200;
	localparam int         DRAIN_LIMIT     = 20000;

	typedef enum logic [1:0] {WAIT_LEN_LO, WAIT_LEN_HI, IN_PAYLOAD} parse_phase_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
	} req_t;

	typedef struct packed {
		logic [31:0] packet_count;
		logic [31:0] byte_count;
		logic [31:0] lost_count;
		logic [31:0] error_count;
		logic [31:0] transfer_count;
		logic [15:0] shortest_record;
		logic [15:0] longest_record;
		logic [15:0] peak_level;
	} snapshot_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	irss_in_if  item_if ();
	irss_out_if result_if ();

	iso_record_stream_statistics_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_if),
		.result    (result_if)
	);

	always #5 clk = ~clk;

	// predictor state
	parse_phase_t phase_m;
	logic [7:0]   len_lo;
	logic [15:0]  rec_len;
	logic [15:0]  remaining;
	logic [7:0]   slot;
	logic [7:0]   low_hold;
	logic [15:0]  run_peak;
	logic [15:0]  peak_hold;
	logic [31:0]  n_packets, n_bytes, n_lost, n_errors, n_transfers;
	logic [15:0]  len_min, len_max;
	logic [2:0]   sb_cfg;

	req_t      pending_reqs[$];
	snapshot_t snapshots_due[$];
	req_t      next_req;
	snapshot_t snap_now, snap_due;
	int        items_queued = 0;
	int        results_taken = 0;
	int        mismatches = 0;
	int        burst_left, gap_left;
	int        hold_left, mode_left, ready_mode;
	bit        long_hold_done;

	function automatic void reset_parser();
		phase_m   = WAIT_LEN_LO;
		len_lo    = '0;
		rec_len   = '0;
		remaining = '0;
		slot      = '0;
		low_hold  = '0;
		run_peak  = '0;
	endfunction

	function automatic void clear_counters();
		peak_hold   = '0;
		n_packets   = '0;
		n_bytes     = '0;
		n_lost      = '0;
		n_errors    = '0;
		n_transfers = '0;
		len_min     = irss_pkg::MIN_LEN_RESET;
		len_max     = '0;
	endfunction

	function automatic void close_record();
		n_packets = n_packets + 32'd1;
		n_bytes   = n_bytes + 32'(rec_len);
		if (rec_len < len_min)
			len_min = rec_len;
		if (rec_len > len_max)
			len_max = rec_len;
		if (run_peak > peak_hold)
			peak_hold = run_peak;
		reset_parser();
	endfunction

	function automatic bit advance_stats(input logic [2:0] op, input logic [7:0] b,
			output snapshot_t snap);
		logic [15:0] len;
		logic [15:0] v;
		logic [16:0] mag;
		int unsigned n;
		bit have;
		snap = '0;
		case (op)
		irss_pkg::OP_BYTE: begin
			case (phase_m)
			WAIT_LEN_LO: begin
				len_lo  = b;
				phase_m = WAIT_LEN_HI;
			end
			WAIT_LEN_HI: begin
				len = {b, len_lo};
				if (len == irss_pkg::LOST_MARKER) begin
					n_lost = n_lost + 32'd1;
					reset_parser();
				end else begin
					rec_len   = len;
					remaining = len;
					slot      = '0;
					low_hold  = '0;
					run_peak  = '0;
					if (len == 16'd0)
						close_record();
					else
						phase_m = IN_PAYLOAD;
				end
			end
			default: begin
				n    = 32'((sb_cfg == 3'd0) ? irss_pkg::DEFAULT_SAMPLE_BYTES : sb_cfg);
				have = 1'b0;
				mag  = '0;
				if (n == 1) begin
					mag  = b[7] ? {9'd256 - {1'b0, b}, 8'h00} : {1'b0, b, 8'h00};
					have = 1'b1;
				end else if (slot == n - 2) begin
					low_hold = b;
				end else if (slot == n - 1) begin
					v    = {b, low_hold};
					mag  = v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
					have = 1'b1;
				end
				if (have && mag > {1'b0, run_peak})
					run_peak = mag[15:0];
				slot = slot + 8'd1;
				if (slot >= n)
					slot = '0;
				remaining = remaining - 16'd1;
				if (remaining == 16'd0)
					close_record();
			end
			endcase
		end
		irss_pkg::OP_END: begin
			if (phase_m == IN_PAYLOAD)
				n_errors = n_errors + 32'd1;
			n_transfers = n_transfers + 32'd1;
			reset_parser();
		end
		irss_pkg::OP_CLR_PEAK: peak_hold = '0;
		irss_pkg::OP_RESTART: clear_counters();
		irss_pkg::OP_FAIL: begin
			n_errors = n_errors + 32'd1;
			reset_parser();
		end
		default: return 1'b0;
		endcase
		snap.packet_count    = n_packets;
		snap.byte_count      = n_bytes;
		snap.lost_count      = n_lost;
		snap.error_count     = n_errors;
		snap.transfer_count  = n_transfers;
		snap.shortest_record = len_min;
		snap.longest_record  = len_max;
		snap.peak_level      = peak_hold;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// sender: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			burst_left    <= 0;
			gap_left      <= 0;
		end else if (!item_if.valid || item_if.ready) begin
			if (gap_left > 0) begin
				gap_left      <= gap_left - 1;
				item_if.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				next_req          = pending_reqs.pop_front();
				item_if.valid     <= 1'b1;
				item_if.op        <= next_req.op;
				item_if.data_byte <= next_req.data;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern in modes, plus one long hold-off while requests queue up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			hold_left       <= 0;
			mode_left       <= 0;
			ready_mode      <= 0;
			long_hold_done  <= 1'b0;
		end else begin
			if (hold_left > 0) begin
				hold_left       <= hold_left - 1;
				result_if.ready <= 1'b0;
			end else if (!long_hold_done && results_taken >= 150
					&& pending_reqs.size() > 16) begin
				long_hold_done  <= 1'b1;
				hold_left       <= LONG_HOLD;
				result_if.ready <= 1'b0;
			end else begin
				case (ready_mode)
				0: result_if.ready <= 1'b1;
				1: result_if.ready <= ($urandom_range(0, 9) < 7);
				default: result_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
			if (mode_left == 0) begin
				mode_left  <= $urandom_range(8, 48);
				ready_mode <= $urandom_range(0, 2);
			end else begin
				mode_left <= mode_left - 1;
			end
		end
	end

	// accepted requests feed the predictor; results are checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_if.valid && item_if.ready) begin
				if (advance_stats(item_if.op, item_if.data_byte, snap_now))
					snapshots_due.push_back(snap_now);
			end
			if (result_if.valid && result_if.ready) begin
				results_taken++;
				if (snapshots_due.size() == 0) begin
					$display("%0t: result with none expected, packet_count %0d", $time,
						result_if.packet_count);
					mismatches++;
				end else begin
					snap_due = snapshots_due.pop_front();
					check_field("packet_count", snap_due.packet_count, result_if.packet_count);
					check_field("byte_count", snap_due.byte_count, result_if.byte_count);
					check_field("lost_count", snap_due.lost_count, result_if.lost_count);
					check_field("error_count", snap_due.error_count, result_if.error_count);
					check_field("transfer_count", snap_due.transfer_count,
						result_if.transfer_count);
					check_field("shortest_record", snap_due.shortest_record,
						result_if.shortest_record);
					check_field("longest_record", snap_due.longest_record,
						result_if.longest_record);
					check_field("peak_level", snap_due.peak_level, result_if.peak_level);
				end
			end
		end
	end

	task automatic send(input logic [2:0] op, input logic [7:0] b);
		req_t r;
		r.op   = op;
		r.data = b;
		pending_reqs.push_back(r);
		if (op <= irss_pkg::OP_FAIL)
			items_queued++;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
		0: return 8'h80;
		1: return 8'h7F;
		2: return 8'h00;
		3: return 8'hFF;
		4: return 8'h81;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_side_op();
		case ($urandom_range(0, 2))
		0: send(irss_pkg::OP_CLR_PEAK, 8'($urandom_range(0, 255)));
		1: send(irss_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
		default: send(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
			8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic send_record(input int len);
		logic [15:0] l;
		l = 16'(len);
		send(irss_pkg::OP_BYTE, l[7:0]);
		send(irss_pkg::OP_BYTE, l[15:8]);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 59) == 0)
				send_side_op();
			send(irss_pkg::OP_BYTE, pick_byte());
		end
	endtask

	task automatic send_transfer(input bit with_long);
		int nrec;
		int r;
		nrec = $urandom_range(1, 4);
		for (int i = 0; i < nrec; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send(irss_pkg::OP_BYTE, irss_pkg::LOST_MARKER[7:0]);
				send(irss_pkg::OP_BYTE, irss_pkg::LOST_MARKER[15:8]);
			end else if (r < 14) begin
				send_record(0);
			end else if (r < 19) begin
				send_record($urandom_range(13, 40));
			end else begin
				send_record($urandom_range(1, 12));
			end
			if ($urandom_range(0, 29) == 0)
				send_side_op();
		end
		if (with_long)
			send_record($urandom_range(256, 264));
		r = $urandom_range(0, 99);
		if (r < 65) begin
			send(irss_pkg::OP_END, 8'($urandom_range(0, 255)));
		end else if (r < 78) begin
			// broken record: random length, mostly cut short
			send(irss_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
			send(irss_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 4))
				send(irss_pkg::OP_BYTE, pick_byte());
			send($urandom_range(0, 1) ? irss_pkg::OP_END : irss_pkg::OP_FAIL,
				8'($urandom_range(0, 255)));
		end else if (r < 86) begin
			send(irss_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
			send(irss_pkg::OP_END, 8'($urandom_range(0, 255)));
		end else if (r < 93) begin
			send(irss_pkg::OP_FAIL, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_idle();
		int waited;
		waited = 0;
		while ((pending_reqs.size() != 0 || item_if.valid || snapshots_due.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (waited >= DRAIN_LIMIT) begin
			$display("%0t: %0d results still outstanding", $time, snapshots_due.size());
			mismatches++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_sample_bytes(input logic [2:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb_cfg    = v;
	endtask

	initial begin
		logic [2:0] cfg_list[6];
		int target;
		cfg_list = '{3'd1, 3'd4, 3'd0, 3'd3, 3'd7, 3'd2};
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		item_if.valid     = 1'b0;
		item_if.op        = irss_pkg::OP_BYTE;
		item_if.data_byte = '0;
		result_if.ready   = 1'b0;
		sb_cfg            = irss_pkg::DEFAULT_SAMPLE_BYTES;
		reset_parser();
		clear_counters();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, at the reset subframe size
		send(OP_UNUSED_FIRST, 8'hFF);
		send(OP_UNUSED_LAST, 8'h00);
		// full-scale samples, negative and positive
		send(irss_pkg::OP_BYTE, 8'h04); send(irss_pkg::OP_BYTE, 8'h00);
		send(irss_pkg::OP_BYTE, 8'h00); send(irss_pkg::OP_BYTE, 8'h80);
		send(irss_pkg::OP_BYTE, 8'hFF); send(irss_pkg::OP_BYTE, 8'h7F);
		// zero-length record, then lost marker
		send(irss_pkg::OP_BYTE, 8'h00); send(irss_pkg::OP_BYTE, 8'h00);
		send(irss_pkg::OP_BYTE, 8'hFF); send(irss_pkg::OP_BYTE, 8'hFF);
		send(irss_pkg::OP_CLR_PEAK, 8'h00);
		// record with a partial subframe only
		send(irss_pkg::OP_BYTE, 8'h01); send(irss_pkg::OP_BYTE, 8'h00);
		send(irss_pkg::OP_BYTE, 8'h7F);
		// transfer end inside a payload
		send(irss_pkg::OP_BYTE, 8'h03); send(irss_pkg::OP_BYTE, 8'h00);
		send(irss_pkg::OP_BYTE, 8'h01);
		send(irss_pkg::OP_END, 8'h00);
		// trailing single length byte
		send(irss_pkg::OP_BYTE, 8'h05); send(irss_pkg::OP_END, 8'h00);
		// failed transfer after a length
		send(irss_pkg::OP_BYTE, 8'h02); send(irss_pkg::OP_BYTE, 8'h00);
		send(irss_pkg::OP_FAIL, 8'h00);
		send(irss_pkg::OP_RESTART, 8'h00);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_sample_bytes(cfg_list[p]);
			target = items_queued + ITEMS_PER_PHASE;
			send_transfer(cfg_list[p] == 3'd4);
			while (items_queued < target)
				send_transfer(1'b0);
			wait_idle();
		end

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
